@@ rtl/core/x86enc_pkg.sv @@
// ----------------------------------------------------------------------------
// x86enc_pkg
// Shared types and encoding constants for the x86 ModRM/SIB operand encoder.
// ----------------------------------------------------------------------------
package x86enc_pkg;

  localparam logic [7:0] EscapeByte = 8'h0F;

  localparam logic [2:0] RegEsp = 3'd4;
  localparam logic [2:0] RegEbp = 3'd5;

  // ModRM mod field codes
  localparam logic [1:0] ModNoDisp = 2'b00;
  localparam logic [1:0] ModDisp8  = 2'b01;
  localparam logic [1:0] ModDisp32 = 2'b10;
  localparam logic [1:0] ModReg    = 2'b11;

  // rm / SIB special register codes
  localparam logic [2:0] RmSib      = 3'd4;
  localparam logic [2:0] RmDisp32   = 3'd5;
  localparam logic [2:0] SibNoIndex = 3'd4;
  localparam logic [2:0] SibNoBase  = 3'd5;

  localparam int unsigned QueueDepth = 2;

  // Classified instruction: every byte already formed, plus presence flags.
  typedef struct packed {
    logic        has_prefix;
    logic [7:0]  prefix;
    logic        has_escape;
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic        has_sib;
    logic [7:0]  sib;
    logic        has_disp;
    logic        disp_long;
    logic [31:0] disp;
  } desc_t;

  typedef enum logic [5:0] {
    PH_PREFIX = 6'b000001,
    PH_ESCAPE = 6'b000010,
    PH_OPCODE = 6'b000100,
    PH_MODRM  = 6'b001000,
    PH_SIB    = 6'b010000,
    PH_DISP   = 6'b100000
  } phase_e;

endpackage

@@ rtl/core/x86enc_req_if.sv @@
// ----------------------------------------------------------------------------
// x86enc_req_if
// Instruction request channel: valid/ready handshake with request fields.
// ----------------------------------------------------------------------------
interface x86enc_req_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [7:0]         prefix_byte;
  logic               has_escape;
  logic [7:0]         opcode;
  logic [2:0]         reg_field;
  logic [2:0]         rm_register;
  logic               has_base;
  logic [2:0]         base_reg;
  logic               has_index;
  logic [2:0]         index_reg;
  logic [1:0]         scale_log2;
  logic signed [31:0] displacement;

  modport source (
    output valid, action, prefix_byte, has_escape, opcode, reg_field, rm_register,
           has_base, base_reg, has_index, index_reg, scale_log2, displacement,
    input  ready
  );

  modport sink (
    input  valid, action, prefix_byte, has_escape, opcode, reg_field, rm_register,
           has_base, base_reg, has_index, index_reg, scale_log2, displacement,
    output ready
  );
endinterface

@@ rtl/core/x86enc_code_if.sv @@
// ----------------------------------------------------------------------------
// x86enc_code_if
// Code byte channel: valid/ready handshake with one byte and a last flag.
// ----------------------------------------------------------------------------
interface x86enc_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last;

  modport source (
    output valid, code_byte, last,
    input  ready
  );

  modport sink (
    input  valid, code_byte, last,
    output ready
  );
endinterface

@@ rtl/core/x86enc_front.sv @@
// ----------------------------------------------------------------------------
// x86enc_front
// Accept requests and classify them into fully formed instruction bytes.
// ----------------------------------------------------------------------------
module x86enc_front (
  x86enc_req_if.sink          req_i,
  input  logic                full_i,
  output logic                push_o,
  output x86enc_pkg::desc_t   desc_o
);
  import x86enc_pkg::*;

  logic [31:0] disp;
  logic        zero;
  logic        fits8;
  logic        use_sib;
  logic        base_esp;
  logic        base_ebp;
  logic [1:0]  mod;
  logic [2:0]  rm;

  assign req_i.ready = ~full_i;
  assign push_o      = req_i.valid & ~full_i;

  assign disp     = req_i.displacement;
  assign zero     = (disp == 32'd0);
  assign fits8    = (&disp[31:7]) | ~(|disp[31:7]);
  assign base_esp = req_i.has_base & (req_i.base_reg == RegEsp);
  assign base_ebp = req_i.has_base & (req_i.base_reg == RegEbp);
  assign use_sib  = req_i.has_index | base_esp | (base_ebp & zero);

  always_comb begin
    desc_o            = '0;
    desc_o.has_prefix = (req_i.prefix_byte != 8'd0);
    desc_o.prefix     = req_i.prefix_byte;
    desc_o.has_escape = req_i.has_escape;
    desc_o.opcode     = req_i.opcode;
    desc_o.disp       = disp;
    mod               = ModNoDisp;
    rm                = req_i.base_reg;

    if (!req_i.action) begin
      mod = ModReg;
      rm  = req_i.rm_register;
    end else begin
      if (use_sib) begin
        rm             = RmSib;
        desc_o.has_sib = 1'b1;
        desc_o.sib[7:3] = req_i.has_index ? {req_i.scale_log2, req_i.index_reg}
                                          : {2'b00, SibNoIndex};
        desc_o.sib[2:0] = req_i.has_base ? req_i.base_reg : SibNoBase;
      end else if (!req_i.has_base) begin
        rm = RmDisp32;
      end

      // displacement size: no base always forces a disp32 with mod 0
      priority if (!req_i.has_base) begin
        mod              = ModNoDisp;
        desc_o.has_disp  = 1'b1;
        desc_o.disp_long = 1'b1;
      end else if (zero) begin
        if (base_ebp) begin
          mod             = ModDisp8;
          desc_o.has_disp = 1'b1;
        end
      end else if (fits8) begin
        mod             = ModDisp8;
        desc_o.has_disp = 1'b1;
      end else begin
        mod              = ModDisp32;
        desc_o.has_disp  = 1'b1;
        desc_o.disp_long = 1'b1;
      end
    end

    desc_o.modrm = {mod, req_i.reg_field, rm};
  end

endmodule

@@ rtl/core/x86enc_queue.sv @@
// ----------------------------------------------------------------------------
// x86enc_queue
// Short descriptor queue between classification and byte emission.
// ----------------------------------------------------------------------------
module x86enc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  x86enc_pkg::desc_t desc_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output x86enc_pkg::desc_t desc_o
);
  import x86enc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  desc_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign desc_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(QueueDepth - 1)) return '0;
    return p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ rtl/core/x86enc_back.sv @@
// ----------------------------------------------------------------------------
// x86enc_back
// Walk the head descriptor one byte per transfer into a registered output.
// ----------------------------------------------------------------------------
module x86enc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  x86enc_pkg::desc_t desc_i,
  output logic              pop_o,
  x86enc_code_if.source     code_o
);
  import x86enc_pkg::*;

  phase_e      phase_q, phase_d, cur_phase, nxt_phase, start_phase;
  logic        fresh_q, fresh_d;
  logic [1:0]  dcnt_q, dcnt_d;
  logic        load;
  logic        is_last;
  logic [7:0]  byte_sel;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  always_comb begin
    priority if (desc_i.has_prefix) begin
      start_phase = PH_PREFIX;
    end else if (desc_i.has_escape) begin
      start_phase = PH_ESCAPE;
    end else begin
      start_phase = PH_OPCODE;
    end
    cur_phase = fresh_q ? start_phase : phase_q;
  end

  always_comb begin
    byte_sel  = desc_i.opcode;
    is_last   = 1'b0;
    nxt_phase = PH_OPCODE;
    unique case (cur_phase)
      PH_PREFIX: begin
        byte_sel  = desc_i.prefix;
        nxt_phase = desc_i.has_escape ? PH_ESCAPE : PH_OPCODE;
      end
      PH_ESCAPE: begin
        byte_sel  = EscapeByte;
        nxt_phase = PH_OPCODE;
      end
      PH_OPCODE: begin
        byte_sel  = desc_i.opcode;
        nxt_phase = PH_MODRM;
      end
      PH_MODRM: begin
        byte_sel  = desc_i.modrm;
        is_last   = ~desc_i.has_sib & ~desc_i.has_disp;
        nxt_phase = desc_i.has_sib ? PH_SIB : PH_DISP;
      end
      PH_SIB: begin
        byte_sel  = desc_i.sib;
        is_last   = ~desc_i.has_disp;
        nxt_phase = PH_DISP;
      end
      PH_DISP: begin
        byte_sel  = desc_i.disp[{dcnt_q, 3'b000} +: 8];
        is_last   = desc_i.disp_long ? (dcnt_q == 2'd3) : 1'b1;
        nxt_phase = PH_DISP;
      end
      default: begin
        byte_sel  = desc_i.opcode;
        is_last   = 1'b1;
        nxt_phase = PH_OPCODE;
      end
    endcase
  end

  // load a byte whenever the output register is empty or being drained
  assign load  = valid_i & (~out_valid_q | code_o.ready);
  assign pop_o = load & is_last;

  always_comb begin
    phase_d     = phase_q;
    fresh_d     = fresh_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q & ~code_o.ready;
    if (load) begin
      out_valid_d = 1'b1;
      if (is_last) begin
        fresh_d = 1'b1;
        dcnt_d  = '0;
      end else begin
        fresh_d = 1'b0;
        phase_d = nxt_phase;
        dcnt_d  = (cur_phase == PH_DISP) ? dcnt_q + 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_sel;
      out_last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OPCODE;
      fresh_q     <= 1'b1;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      fresh_q     <= fresh_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign code_o.valid     = out_valid_q;
  assign code_o.code_byte = out_byte_q;
  assign code_o.last      = out_last_q;

endmodule

@@ rtl/core/x86_modrm_sib_operand_encoder.sv @@
// Datapath: a request's bytes pass through the descriptor queue and the output register.
// Throughput: one code byte per cycle while the receiver is ready; a request is 2 to 9
//   bytes long. The request side never waits on the output port while the two-entry
//   descriptor queue has room.
// Reset: asynchronous, active low; empties the queue and the output register.
// ----------------------------------------------------------------------------
// x86_modrm_sib_operand_encoder
// Encode one 32-bit x86 register or memory operand instruction into bytes.
// ----------------------------------------------------------------------------
module x86_modrm_sib_operand_encoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  x86enc_req_if.sink    req_i,
  x86enc_code_if.source code_o
);
  import x86enc_pkg::*;

  // front side: classify and push
  logic  push;
  desc_t push_desc;
  logic  full;

  // back side: head of queue and pop
  logic  head_valid;
  desc_t head_desc;
  logic  pop;

  // Classify the request combinationally: prefix/escape flags, ModRM, optional
  // SIB and the displacement size all land in one descriptor per transfer.
  x86enc_front u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .desc_o (push_desc)
  );

  // Hold classified instructions so the request side keeps moving while the
  // back end drains a long instruction.
  x86enc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .desc_o  (head_desc)
  );

  // Emit the head instruction byte by byte; drop it from the queue on the
  // transfer into the output register of its last byte.
  x86enc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .desc_i  (head_desc),
    .pop_o   (pop),
    .code_o  (code_o)
  );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the x86 ModRM/SIB operand encoder. Requests go out
// through a valid/ready driver fed from a queue. A predictor in the bench
// expands each accepted request into its byte sequence, and the monitor
// compares each code byte transfer with the oldest expected byte. The run
// covers directed cases first and then random requests under changing idle
// and stall patterns, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import x86enc_pkg::*;

  // Operand form codes carried by the action field
  localparam logic ActRegReg = 1'b0;
  localparam logic ActRegMem = 1'b1;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned HoldoffCycles = 80;
  localparam int unsigned DrainCycles   = 12;

  typedef struct {
    logic               action;
    logic [7:0]         prefix_byte;
    logic               has_escape;
    logic [7:0]         opcode;
    logic [2:0]         reg_field;
    logic [2:0]         rm_register;
    logic               has_base;
    logic [2:0]         base_reg;
    logic               has_index;
    logic [2:0]         index_reg;
    logic [1:0]         scale_log2;
    logic signed [31:0] displacement;
  } instr_req_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last;
  } code_xfer_t;

  logic clk_i;
  logic rst_ni;

  x86enc_req_if  req_if ();
  x86enc_code_if code_if ();

  x86_modrm_sib_operand_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .code_o (code_if)
  );

  // Requests waiting for the driver, and bytes waiting for the monitor
  instr_req_t pending_reqs[$];
  code_xfer_t expected_bytes[$];

  int unsigned reqs_queued   = 0;  // pushed by the stimulus process
  int unsigned reqs_offered  = 0;  // put on the bus by the driver
  int unsigned reqs_accepted = 0;  // transfers seen at a rising edge
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        rx_holdoff     = 1'b0;
  event        holdoff_kick;

  // --------------------------------------------------------------------------
  // Clock and cycle limit
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Append one expected byte, not yet marked last
  function automatic void expect_byte(logic [7:0] b);
    code_xfer_t x;

    x.code_byte    = b;
    x.last         = 1'b0;
    expected_bytes = {expected_bytes, x};
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: expand one request into its encoded bytes, last byte marked
  // --------------------------------------------------------------------------
  function automatic void encode_request(instr_req_t r);
    logic [1:0] mod_bits;
    logic [2:0] rm_bits;
    logic [7:0] sib_byte;
    logic       use_sib;
    logic       disp_zero;
    logic       disp_fits8;
    int         disp_len;

    if (r.prefix_byte != 8'h00) expect_byte(r.prefix_byte);
    if (r.has_escape) expect_byte(EscapeByte);
    expect_byte(r.opcode);

    if (r.action == ActRegReg) begin
      expect_byte({ModReg, r.reg_field, r.rm_register});
    end else begin
      disp_zero  = (r.displacement == 32'sd0);
      disp_fits8 = (r.displacement >= -32'sd128) && (r.displacement <= 32'sd127);
      use_sib    = r.has_index || (r.has_base && r.base_reg == RegEsp) ||
                   (r.has_base && r.base_reg == RegEbp && disp_zero);

      // Pick mod and displacement length. No base always means mod 0 with a
      // disp32, in both the plain and the SIB form.
      mod_bits = ModNoDisp;
      disp_len = 0;
      if (!r.has_base) begin
        disp_len = 4;
      end else if (disp_zero) begin
        // EBP base with zero displacement: only reachable through SIB here,
        // and it still needs a disp8 of zero
        if (r.base_reg == RegEbp) begin
          mod_bits = ModDisp8;
          disp_len = 1;
        end
      end else if (disp_fits8) begin
        mod_bits = ModDisp8;
        disp_len = 1;
      end else begin
        mod_bits = ModDisp32;
        disp_len = 4;
      end

      if (use_sib) rm_bits = RmSib;
      else if (r.has_base) rm_bits = r.base_reg;
      else rm_bits = RmDisp32;

      // No index drops the scale and encodes index 4; index register four
      // given explicitly passes through as is
      sib_byte[7:6] = r.has_index ? r.scale_log2 : 2'b00;
      sib_byte[5:3] = r.has_index ? r.index_reg : SibNoIndex;
      sib_byte[2:0] = r.has_base ? r.base_reg : SibNoBase;

      expect_byte({mod_bits, r.reg_field, rm_bits});
      if (use_sib) expect_byte(sib_byte);
      for (int k = 0; k < disp_len; k++) begin
        expect_byte(r.displacement[8*k +: 8]);
      end
    end
    expected_bytes[$].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic instr_req_t random_request();
    instr_req_t r;
    int         disp_edges[4] = '{-129, -128, 127, 128};

    r.action      = ($urandom_range(3) == 0) ? ActRegReg : ActRegMem;
    r.prefix_byte = $urandom_range(1) ? 8'($urandom) : 8'h00;
    r.has_escape  = 1'($urandom_range(1));
    r.opcode      = 8'($urandom);
    r.reg_field   = 3'($urandom);
    r.rm_register = 3'($urandom);
    r.has_base    = ($urandom_range(4) != 0);
    // Lean on ESP and EBP bases, they steer the SIB and disp8 rules
    if ($urandom_range(2) == 0) r.base_reg = $urandom_range(1) ? RegEsp : RegEbp;
    else r.base_reg = 3'($urandom);
    r.has_index   = 1'($urandom_range(1));
    r.index_reg   = 3'($urandom);
    r.scale_log2  = 2'($urandom);
    case ($urandom_range(5))
      0: r.displacement = 32'sd0;
      1: r.displacement = 32'($urandom_range(255)) - 32'sd128;
      2: r.displacement = 32'(disp_edges[$urandom_range(3)]);
      default: r.displacement = 32'($urandom);
    endcase
    return r;
  endfunction

  // Memory form with the addressing fields fixed and the rest random
  function automatic instr_req_t mem_req(logic has_base, logic [2:0] base_reg,
                                         logic has_index, logic [2:0] index_reg,
                                         logic [1:0] scale, logic [31:0] disp);
    instr_req_t r;

    r              = random_request();
    r.action       = ActRegMem;
    r.has_base     = has_base;
    r.base_reg     = base_reg;
    r.has_index    = has_index;
    r.index_reg    = index_reg;
    r.scale_log2   = scale;
    r.displacement = disp;
    return r;
  endfunction

  function automatic void queue_request(instr_req_t r);
    pending_reqs = {pending_reqs, r};
    reqs_queued++;
  endfunction

  task automatic queue_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) queue_request(random_request());
  endtask

  // Hold until every queued request has transferred and every byte arrived
  task automatic wait_drained();
    while (reqs_accepted != reqs_queued || expected_bytes.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver: advance to the next request once the current one has
  // transferred; drive on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    instr_req_t nxt;

    if (rst_ni && reqs_accepted == reqs_offered) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        reqs_offered++;
        req_if.valid        <= 1'b1;
        req_if.action       <= nxt.action;
        req_if.prefix_byte  <= nxt.prefix_byte;
        req_if.has_escape   <= nxt.has_escape;
        req_if.opcode       <= nxt.opcode;
        req_if.reg_field    <= nxt.reg_field;
        req_if.rm_register  <= nxt.rm_register;
        req_if.has_base     <= nxt.has_base;
        req_if.base_reg     <= nxt.base_reg;
        req_if.has_index    <= nxt.has_index;
        req_if.index_reg    <= nxt.index_reg;
        req_if.scale_log2   <= nxt.scale_log2;
        req_if.displacement <= nxt.displacement;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall at random, and hold ready low through a long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      code_if.ready <= !rx_holdoff && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Count the hold-off in rising edges so the receiver reads a settled flag
  always begin
    @(holdoff_kick);
    @(posedge clk_i);
    rx_holdoff = 1'b1;
    repeat (HoldoffCycles) @(posedge clk_i);
    rx_holdoff = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on request transfers, check each code byte transfer
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    instr_req_t seen;
    code_xfer_t exp_byte;

    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        seen.action       = req_if.action;
        seen.prefix_byte  = req_if.prefix_byte;
        seen.has_escape   = req_if.has_escape;
        seen.opcode       = req_if.opcode;
        seen.reg_field    = req_if.reg_field;
        seen.rm_register  = req_if.rm_register;
        seen.has_base     = req_if.has_base;
        seen.base_reg     = req_if.base_reg;
        seen.has_index    = req_if.has_index;
        seen.index_reg    = req_if.index_reg;
        seen.scale_log2   = req_if.scale_log2;
        seen.displacement = req_if.displacement;
        encode_request(seen);
        reqs_accepted++;
      end

      if (code_if.valid && code_if.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("code_byte: unexpected transfer, got %h (last %b)",
                 code_if.code_byte, code_if.last);
          mismatches++;
        end else begin
          exp_byte = expected_bytes.pop_front();
          if (code_if.code_byte !== exp_byte.code_byte) begin
            $error("code_byte mismatch: expected %h, got %h",
                   exp_byte.code_byte, code_if.code_byte);
            mismatches++;
          end
          if (code_if.last !== exp_byte.last) begin
            $error("last mismatch: expected %b, got %b", exp_byte.last, code_if.last);
            mismatches++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    instr_req_t r;

    // Drive every input to a known value before the first edge
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.action        = ActRegReg;
    req_if.prefix_byte   = 8'h00;
    req_if.has_escape    = 1'b0;
    req_if.opcode        = 8'h00;
    req_if.reg_field     = 3'd0;
    req_if.rm_register   = 3'd0;
    req_if.has_base      = 1'b0;
    req_if.base_reg      = 3'd0;
    req_if.has_index     = 1'b0;
    req_if.index_reg     = 3'd0;
    req_if.scale_log2    = 2'd0;
    req_if.displacement  = 32'sd0;
    code_if.ready        = 1'b0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: register form at both field extremes
    r = random_request();
    r.action = ActRegReg;  r.prefix_byte = 8'h00;  r.has_escape = 1'b0;
    r.opcode = 8'h00;      r.reg_field = 3'd0;     r.rm_register = 3'd0;
    queue_request(r);
    r.prefix_byte = 8'hFF; r.has_escape = 1'b1;    r.opcode = 8'hFF;
    r.reg_field = 3'd7;    r.rm_register = 3'd7;
    queue_request(r);

    // Directed: plain memory forms and the disp8/disp32 boundaries
    queue_request(mem_req(1'b0, 3'd0, 1'b0, 3'd0, 2'd0, 32'h0000_0000));
    queue_request(mem_req(1'b1, 3'd0, 1'b0, 3'd0, 2'd0, 32'h0000_0000));
    queue_request(mem_req(1'b1, 3'd3, 1'b0, 3'd0, 2'd0, 32'h0000_007F));
    queue_request(mem_req(1'b1, 3'd3, 1'b0, 3'd0, 2'd0, 32'hFFFF_FF80));
    queue_request(mem_req(1'b1, 3'd3, 1'b0, 3'd0, 2'd0, 32'h0000_0080));
    queue_request(mem_req(1'b1, 3'd3, 1'b0, 3'd0, 2'd0, 32'hFFFF_FF7F));

    // Directed: ESP and EBP bases
    queue_request(mem_req(1'b1, RegEsp, 1'b0, 3'd0, 2'd3, 32'h0000_0000));
    queue_request(mem_req(1'b1, RegEsp, 1'b0, 3'd0, 2'd0, 32'h0000_0005));
    queue_request(mem_req(1'b1, RegEbp, 1'b0, 3'd0, 2'd0, 32'h0000_0000));
    queue_request(mem_req(1'b1, RegEbp, 1'b0, 3'd0, 2'd0, 32'h7FFF_FFFF));
    queue_request(mem_req(1'b1, RegEbp, 1'b0, 3'd0, 2'd0, 32'hFFFF_FFFF));

    // Directed: index forms, index register four, SIB with no base
    queue_request(mem_req(1'b1, 3'd2, 1'b1, 3'd4, 2'd3, 32'h0000_0000));
    queue_request(mem_req(1'b0, 3'd0, 1'b1, 3'd7, 2'd2, 32'h0000_0000));
    queue_request(mem_req(1'b1, RegEbp, 1'b1, 3'd0, 2'd1, 32'h0000_0000));
    queue_request(mem_req(1'b0, 3'd6, 1'b0, 3'd0, 2'd0, 32'h8000_0000));

    // Directed: longest encoding, nine bytes
    r = mem_req(1'b1, 3'd7, 1'b1, 3'd5, 2'd1, 32'h8000_0000);
    r.prefix_byte = 8'hFF;  r.has_escape = 1'b1;
    queue_request(r);
    wait_drained();

    // Random, no idling on either side
    queue_random(85);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering back to back
    @(posedge clk_i);
    -> holdoff_kick;
    queue_random(14);
    wait_drained();

    // Sender mostly idle
    @(posedge clk_i);
    send_idle_pct = 87;
    queue_random(85);
    wait_drained();

    // Receiver mostly stalling
    @(posedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 87;
    queue_random(85);
    wait_drained();

    // Both sides idle now and then
    @(posedge clk_i);
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    queue_random(85);
    wait_drained();

    // Let any stray bytes show up before the verdict
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
